### hdl/sjfq_pkg.sv
// shared types and codes for the shortest-job-first queue
package sjfq_pkg;

  localparam int LEN_BITS   = 32;
  localparam int TAG_PORT   = 16;
  localparam int COUNT_PORT = 5;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

### hdl/sjfq_ctrl.sv
// controller state machine: handshakes and sequencing of one operation
module sjfq_ctrl
  import sjfq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        // no input beat is taken while reset is held
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hdl/sjfq_datapath.sv
// datapath: sorted row of job cells, held count and result register
module sjfq_datapath
  import sjfq_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic                  func,
  input  logic [TAG_PORT-1:0]   job_tag,
  input  logic [LEN_BITS-1:0]   job_length,
  output logic [1:0]            status,
  output logic [TAG_PORT-1:0]   out_tag,
  output logic [LEN_BITS-1:0]   out_length,
  output logic [COUNT_PORT-1:0] queued_count
);

  localparam int TW = (TAG_BITS < TAG_PORT) ? TAG_BITS : TAG_PORT;
  localparam int CW = $clog2(DEPTH + 1);

  // operation register
  func_t               op_func;
  logic [TW-1:0]       op_tag;
  logic [LEN_BITS-1:0] op_len;

  logic [TW-1:0]       cell_tag [DEPTH];
  logic [LEN_BITS-1:0] cell_len [DEPTH];
  logic [CW-1:0]       count;

  status_t             res_status;
  logic [TW-1:0]       res_tag;
  logic [LEN_BITS-1:0] res_len;

  logic [DEPTH-1:0]    behind;
  logic                is_full;
  logic                is_empty;
  logic [CW+COUNT_PORT-1:0] count_ext;
  logic [TAG_PORT+TW-1:0]   tag_ext;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  // cell sits at or after the insertion point of the new job
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      behind[i] = (CW'(i) >= count) || (cell_len[i] > op_len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func_t'(func);
      op_tag  <= job_tag[TW-1:0];
      op_len  <= job_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_func == FUNC_PUSH) begin
        if (!is_full) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (behind[i]) begin
              if (i == 0) begin
                cell_tag[i] <= op_tag;
                cell_len[i] <= op_len;
              end else if (!behind[i-1]) begin
                cell_tag[i] <= op_tag;
                cell_len[i] <= op_len;
              end else begin
                cell_tag[i] <= cell_tag[i-1];
                cell_len[i] <= cell_len[i-1];
              end
            end
          end
        end
      end else if (!is_empty) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          cell_tag[i] <= cell_tag[i+1];
          cell_len[i] <= cell_len[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (op_func == FUNC_PUSH) begin
        if (!is_full) count <= count + CW'(1);
      end else if (!is_empty) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_tag <= '0;
      res_len <= '0;
      if (op_func == FUNC_PUSH) begin
        res_status <= is_full ? STAT_FULL : STAT_OK;
      end else if (is_empty) begin
        res_status <= STAT_EMPTY;
      end else begin
        res_status <= STAT_OK;
        res_tag    <= cell_tag[0];
        res_len    <= cell_len[0];
      end
    end
  end

  assign count_ext    = {{COUNT_PORT{1'b0}}, count};
  assign tag_ext      = {{TAG_PORT{1'b0}}, res_tag};
  assign status       = res_status;
  assign out_tag      = tag_ext[TAG_PORT-1:0];
  assign out_length   = res_len;
  assign queued_count = count_ext[COUNT_PORT-1:0];

endmodule

### hdl/shortest_job_first_queue_core.sv
// top level of the shortest-job-first queue
//
//  channel  handshake             payload
//  input    in_valid / in_ready   func, job_tag, job_length
//  output   out_valid / out_ready status, out_tag, out_length, queued_count
//
// one operation at a time: accept, the exec state in the cell row, then the result
// beat; a new item is taken only after the result beat, set by the controller sequence
// every cell compares its key with the new job in the same cycle
// rst is synchronous; it empties the queue, cell contents are left as they are
// a stalled result beat holds the input side off until it is taken
module shortest_job_first_queue_core
  import sjfq_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [TAG_PORT-1:0]   job_tag,
  input  logic [LEN_BITS-1:0]   job_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [TAG_PORT-1:0]   out_tag,
  output logic [LEN_BITS-1:0]   out_length,
  output logic [COUNT_PORT-1:0] queued_count
);

  cmd_t cmd;

  sjfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sjfq_datapath #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .job_tag      (job_tag),
    .job_length   (job_length),
    .status       (status),
    .out_tag      (out_tag),
    .out_length   (out_length),
    .queued_count (queued_count)
  );

endmodule
